@@ hdl/cdss_pkg.sv @@
// Shared types, character codes and line-format tables for the declaration symbol scanner.
// Depends on nothing; the controller, the datapath and the top level import it.
package cdss_pkg;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_NL     = 8'h0A;

    localparam logic [1:0] LA_NONE  = 2'd0;
    localparam logic [1:0] LA_SLASH = 2'd1;
    localparam logic [1:0] LA_STAR  = 2'd2;

    // Keywords in upper case, right-justified, first character highest.
    localparam logic [63:0] KW_INT      = "INT";
    localparam logic [63:0] KW_STRUCT   = "STRUCT";
    localparam logic [63:0] KW_LONG     = "LONG";
    localparam logic [63:0] KW_CHAR     = "CHAR";
    localparam logic [63:0] KW_UNSIGNED = "UNSIGNED";
    localparam logic [63:0] KW_STATIC   = "STATIC";
    localparam logic [63:0] KW_EXTERN   = "EXTERN";
    localparam logic [63:0] KW_INCLUDE  = "INCLUDE";
    localparam logic [63:0] KW_DEFINE   = "DEFINE";
    localparam logic [63:0] KW_IFDEF    = "IFDEF";
    localparam logic [63:0] KW_ENDIF    = "ENDIF";
    localparam logic [63:0] KW_H        = "H";

    typedef enum logic [2:0] {
        FMT_HASH2,
        FMT_INCL,
        FMT_TYPE_EXT,
        FMT_PAIR,
        FMT_PLAIN
    } fmt_t;

    typedef enum logic [1:0] {
        SEG_CHAR,
        SEG_NAME,
        SEG_END
    } seg_kind_t;

    typedef struct packed {
        seg_kind_t  kind;
        logic [7:0] ch;
        logic [1:0] sel;
    } seg_t;

    typedef struct packed {
        logic ready;
        logic prep;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic line_start;
        logic line_done;
    } status_t;

    function automatic logic [7:0] upper_of(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    endfunction

    function automatic seg_t mk_char(input logic [7:0] c);
        seg_t s;
        s.kind = SEG_CHAR;
        s.ch   = c;
        s.sel  = 2'd0;
        return s;
    endfunction

    function automatic seg_t mk_name(input logic [1:0] k);
        seg_t s;
        s.kind = SEG_NAME;
        s.ch   = CH_SPACE;
        s.sel  = k;
        return s;
    endfunction

    // Segment list of each line format; the newline closes every list.
    function automatic seg_t seg_of(input fmt_t f, input logic [2:0] step);
        seg_t s;
        s.kind = SEG_END;
        s.ch   = CH_NL;
        s.sel  = 2'd0;
        unique case (f)
            FMT_HASH2:
            begin
                if (step == 3'd0) s = mk_char(CH_HASH);
                if (step == 3'd1) s = mk_name(2'd1);
                if (step == 3'd2) s = mk_char(CH_SPACE);
                if (step == 3'd3) s = mk_name(2'd2);
            end
            FMT_INCL:
            begin
                if (step == 3'd0) s = mk_char(CH_HASH);
                if (step == 3'd1) s = mk_name(2'd0);
                if (step == 3'd2) s = mk_char(CH_SPACE);
                if (step == 3'd3) s = mk_name(2'd1);
                if (step == 3'd4) s = mk_char(CH_DOT);
                if (step == 3'd5) s = mk_name(2'd2);
            end
            FMT_TYPE_EXT:
            begin
                if (step == 3'd0) s = mk_name(2'd0);
                if (step == 3'd1) s = mk_char(CH_SPACE);
                if (step == 3'd2) s = mk_name(2'd1);
                if (step == 3'd3) s = mk_char(CH_SPACE);
                if (step == 3'd4) s = mk_name(2'd2);
            end
            FMT_PAIR:
            begin
                if (step == 3'd0) s = mk_name(2'd1);
                if (step == 3'd1) s = mk_char(CH_SPACE);
                if (step == 3'd2) s = mk_name(2'd2);
            end
            default:
            begin
                if (step == 3'd0) s = mk_name(2'd2);
            end
        endcase
        return s;
    endfunction

endpackage

@@ hdl/c_declaration_symbol_scanner_unit.sv @@
// Top level of the declaration symbol scanner: stream ports, controller and datapath.
// Depends on cdss_pkg, cdss_ctrl and cdss_dp.
//
// Throughput: a byte that emits no line is taken, and the next byte may follow in
// the next cycle. A byte that ends a non-keyword name stalls the input for a setup state,
// then an emission state that sends each line character (newline included) and skips each
// empty name of the line format; the input reopens the cycle after the newline is taken.
// Reset (rst_n low, asynchronous) clears depths, literal and comment tracking, the
// identifier and the three-name history; no clearing pass is needed.
module c_declaration_symbol_scanner_unit #(
    parameter int IDENT_MAX = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] source_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] line_char
    output logic       m_axis_tlast    // line_end
);
    import cdss_pkg::*;

    cmd_t    cmd;
    status_t st;

    // The controller owns the handshake phase; the datapath does all byte work.
    cdss_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .cmd   (cmd)
    );

    cdss_dp #(
        .IDENT_MAX (IDENT_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_valid  (s_axis_tvalid),
        .in_byte   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (m_axis_tdata),
        .out_end   (m_axis_tlast)
    );

    // Input is open only while no line is being set up or sent.
    assign s_axis_tready = cmd.ready;

endmodule

@@ hdl/cdss_ctrl.sv @@
// Controller of the declaration symbol scanner: sequences accept, line setup and emission.
// Depends on cdss_pkg for the command and status structs.
module cdss_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  cdss_pkg::status_t st,
    output cdss_pkg::cmd_t    cmd
);
    import cdss_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_EMIT
    } state_t;

    state_t state_reg;
    cmd_t   cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd_reg   <= '{ready: 1'b1, prep: 1'b0, emit: 1'b0};
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (st.line_start)
                    begin
                        state_reg <= S_PREP;
                        cmd_reg   <= '{ready: 1'b0, prep: 1'b1, emit: 1'b0};
                    end
                end
                S_PREP:
                begin
                    state_reg <= S_EMIT;
                    cmd_reg   <= '{ready: 1'b0, prep: 1'b0, emit: 1'b1};
                end
                default:
                begin
                    if (st.line_done)
                    begin
                        state_reg <= S_IDLE;
                        cmd_reg   <= '{ready: 1'b1, prep: 1'b0, emit: 1'b0};
                    end
                end
            endcase
        end
    end

    assign cmd = cmd_reg;

    a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({cmd.ready, cmd.prep, cmd.emit}))
        else $error("controller commands overlap");
    a_prep_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.prep |=> cmd.emit)
        else $error("line setup not followed by emission");
    a_done_to_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && st.line_done) |=> cmd.ready)
        else $error("input not reopened after the newline");
    a_start_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        st.line_start |-> cmd.ready)
        else $error("line started outside idle");

endmodule

@@ hdl/cdss_dp.sv @@
// Datapath of the declaration symbol scanner: lexical state, identifier and history
// registers, line format selection and the character emitter. Depends on cdss_pkg.
module cdss_dp #(
    parameter int IDENT_MAX = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cdss_pkg::cmd_t    cmd,
    output cdss_pkg::status_t st,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_char,
    output logic              out_end
);
    import cdss_pkg::*;

    localparam int LW = $clog2(IDENT_MAX + 1);

    logic signed [7:0]          brace_depth_reg, brace_depth_next;
    logic [7:0]                 comment_depth_reg, comment_depth_next;
    logic                       in_lit_reg, in_lit_next;
    logic [7:0]                 lit_delim_reg, lit_delim_next;
    logic [7:0]                 prev_lit_reg, prev_lit_next;
    logic [1:0]                 la_reg, la_next;
    logic [LW-1:0]              id_len_reg, id_len_next;
    logic                       too_long_reg, too_long_next;
    logic [IDENT_MAX-1:0][7:0]  id_chars_reg, id_chars_next;
    logic [IDENT_MAX-1:0][7:0]  hist_chars_reg [3];
    logic [LW-1:0]              hist_len_reg [3];
    logic                       finish;
    logic [LW-1:0]              fin_len;
    logic                       accept;
    logic                       is_kw;

    fmt_t                       fmt_reg, fmt_next;
    logic [2:0]                 step_reg;
    logic [LW-1:0]              pos_reg;
    seg_t                       seg;
    logic [LW-1:0]              sel_len;
    logic [7:0]                 name_char;
    logic                       name_empty;
    logic                       out_fire;

    function automatic logic name_is(input logic [IDENT_MAX-1:0][7:0] s,
                                     input logic [LW-1:0] n,
                                     input logic [63:0] kw, input int kl);
        logic [IDENT_MAX+7:0][7:0] p;
        logic ok;
        p  = {64'd0, s};
        ok = (int'(n) == kl);
        for (int i = 0; i < 8; i++)
        begin
            if (i < kl)
            begin
                if (upper_of(p[i]) != kw[8*(kl-1-i) +: 8]) ok = 1'b0;
            end
        end
        return ok;
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    assign accept = in_valid && cmd.ready;

    // Lexical step for the byte on the input.
    always_comb
    begin
        logic [7:0] lc;
        brace_depth_next   = brace_depth_reg;
        comment_depth_next = comment_depth_reg;
        in_lit_next        = in_lit_reg;
        lit_delim_next     = lit_delim_reg;
        prev_lit_next      = prev_lit_reg;
        la_next            = LA_NONE;
        id_len_next        = id_len_reg;
        too_long_next      = too_long_reg;
        id_chars_next      = id_chars_reg;
        finish             = 1'b0;
        lc                 = in_byte;
        if (la_reg == LA_SLASH && in_byte == CH_STAR)
        begin
            if (comment_depth_reg != 8'd255) comment_depth_next = comment_depth_reg + 8'd1;
        end
        else if (la_reg == LA_STAR && in_byte == CH_SLASH)
        begin
            if (comment_depth_reg != 8'd0) comment_depth_next = comment_depth_reg - 8'd1;
        end
        else if (in_byte == CH_SLASH)
        begin
            id_len_next   = '0;
            too_long_next = 1'b0;
            la_next       = LA_SLASH;
        end
        else if (comment_depth_reg != 8'd0)
        begin
            if (in_byte == CH_STAR)
                la_next = LA_STAR;
            else
            begin
                id_len_next   = '0;
                too_long_next = 1'b0;
            end
        end
        else if (in_lit_reg)
        begin
            if (in_byte == CH_BSLASH && prev_lit_reg == CH_BSLASH) lc = 8'd0;
            if (lc == lit_delim_reg && prev_lit_reg != CH_BSLASH) in_lit_next = 1'b0;
            prev_lit_next = lc;
        end
        else if (in_byte == CH_SQUOTE || in_byte == CH_DQUOTE)
        begin
            in_lit_next    = 1'b1;
            prev_lit_next  = 8'd0;
            lit_delim_next = in_byte;
        end
        else if (in_byte == CH_LBRACE)
        begin
            if (brace_depth_reg != 8'sd127) brace_depth_next = brace_depth_reg + 8'sd1;
        end
        else if (in_byte == CH_RBRACE)
        begin
            id_len_next   = '0;
            too_long_next = 1'b0;
            if (brace_depth_reg != -8'sd128) brace_depth_next = brace_depth_reg - 8'sd1;
        end
        else if (brace_depth_reg != 8'sd0)
        begin
            id_len_next = id_len_reg;
        end
        else if (id_len_reg == '0)
        begin
            if (is_letter(in_byte) || in_byte == CH_USCORE)
            begin
                id_chars_next[0] = in_byte;
                id_len_next      = LW'(1);
                too_long_next    = 1'b0;
            end
        end
        else if (is_letter(in_byte) || (in_byte >= 8'h30 && in_byte <= 8'h39) ||
                 in_byte == CH_USCORE || in_byte == CH_DOLLAR)
        begin
            if (int'(id_len_reg) < IDENT_MAX)
            begin
                for (int i = 0; i < IDENT_MAX; i++)
                begin
                    if (id_len_reg == LW'(i)) id_chars_next[i] = in_byte;
                end
                id_len_next = id_len_reg + LW'(1);
            end
            else
                too_long_next = 1'b1;
        end
        else
        begin
            finish        = 1'b1;
            id_len_next   = '0;
            too_long_next = 1'b0;
        end
    end

    assign fin_len = too_long_reg ? '0 : id_len_reg;

    assign is_kw = name_is(id_chars_reg, fin_len, KW_INT, 3) ||
                   name_is(id_chars_reg, fin_len, KW_STRUCT, 6) ||
                   name_is(id_chars_reg, fin_len, KW_LONG, 4) ||
                   name_is(id_chars_reg, fin_len, KW_CHAR, 4) ||
                   name_is(id_chars_reg, fin_len, KW_UNSIGNED, 8) ||
                   name_is(id_chars_reg, fin_len, KW_STATIC, 6) ||
                   name_is(id_chars_reg, fin_len, KW_EXTERN, 6) ||
                   name_is(id_chars_reg, fin_len, KW_INCLUDE, 7) ||
                   name_is(id_chars_reg, fin_len, KW_DEFINE, 6) ||
                   name_is(id_chars_reg, fin_len, KW_IFDEF, 5) ||
                   name_is(id_chars_reg, fin_len, KW_ENDIF, 5);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brace_depth_reg   <= '0;
            comment_depth_reg <= '0;
            in_lit_reg        <= 1'b0;
            lit_delim_reg     <= '0;
            prev_lit_reg      <= '0;
            la_reg            <= LA_NONE;
            id_len_reg        <= '0;
            too_long_reg      <= 1'b0;
            for (int k = 0; k < 3; k++) hist_len_reg[k] <= '0;
        end
        else if (accept)
        begin
            brace_depth_reg   <= brace_depth_next;
            comment_depth_reg <= comment_depth_next;
            in_lit_reg        <= in_lit_next;
            lit_delim_reg     <= lit_delim_next;
            prev_lit_reg      <= prev_lit_next;
            la_reg            <= la_next;
            id_len_reg        <= id_len_next;
            too_long_reg      <= too_long_next;
            if (finish)
            begin
                hist_len_reg[0] <= hist_len_reg[1];
                hist_len_reg[1] <= hist_len_reg[2];
                hist_len_reg[2] <= fin_len;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_chars_reg <= id_chars_next;
            if (finish)
            begin
                hist_chars_reg[0] <= hist_chars_reg[1];
                hist_chars_reg[1] <= hist_chars_reg[2];
                hist_chars_reg[2] <= id_chars_reg;
            end
        end
    end

    // Line format from the updated history, taken in the setup cycle.
    always_comb
    begin
        logic [IDENT_MAX+7:0][7:0] p1;
        logic ext;
        p1  = {64'd0, hist_chars_reg[1]};
        ext = name_is(hist_chars_reg[0], hist_len_reg[0], KW_EXTERN, 6) ||
              name_is(hist_chars_reg[0], hist_len_reg[0], KW_STATIC, 6);
        priority if (name_is(hist_chars_reg[1], hist_len_reg[1], KW_DEFINE, 6))
            fmt_next = FMT_HASH2;
        else if (name_is(hist_chars_reg[0], hist_len_reg[0], KW_INCLUDE, 7) &&
                 name_is(hist_chars_reg[2], hist_len_reg[2], KW_H, 1))
            fmt_next = FMT_INCL;
        else if (int'(hist_len_reg[1]) == 5 && upper_of(p1[2]) == 8'h44 &&
                 upper_of(p1[3]) == 8'h45 && upper_of(p1[4]) == 8'h46)
            fmt_next = FMT_HASH2;
        else if (name_is(hist_chars_reg[1], hist_len_reg[1], KW_CHAR, 4) ||
                 name_is(hist_chars_reg[1], hist_len_reg[1], KW_INT, 3) ||
                 name_is(hist_chars_reg[1], hist_len_reg[1], KW_UNSIGNED, 8) ||
                 name_is(hist_chars_reg[1], hist_len_reg[1], KW_LONG, 4))
            fmt_next = ext ? FMT_TYPE_EXT : FMT_PAIR;
        else if (name_is(hist_chars_reg[1], hist_len_reg[1], KW_STRUCT, 6))
            fmt_next = FMT_PAIR;
        else
            fmt_next = FMT_PLAIN;
    end

    // Emitter: walks the segment list, one character per cycle while the receiver is ready.
    assign seg = seg_of(fmt_reg, step_reg);

    always_comb
    begin
        logic [IDENT_MAX-1:0][7:0] nm;
        unique case (seg.sel)
            2'd0:
            begin
                nm      = hist_chars_reg[0];
                sel_len = hist_len_reg[0];
            end
            2'd1:
            begin
                nm      = hist_chars_reg[1];
                sel_len = hist_len_reg[1];
            end
            default:
            begin
                nm      = hist_chars_reg[2];
                sel_len = hist_len_reg[2];
            end
        endcase
        name_char = nm[0];
        for (int i = 0; i < IDENT_MAX; i++)
        begin
            if (pos_reg == LW'(i)) name_char = nm[i];
        end
    end

    assign name_empty = (seg.kind == SEG_NAME) && (pos_reg >= sel_len);
    assign out_valid  = cmd.emit && !name_empty;
    assign out_char   = (seg.kind == SEG_NAME) ? name_char : seg.ch;
    assign out_end    = (seg.kind == SEG_END);
    assign out_fire   = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg  <= FMT_PLAIN;
            step_reg <= '0;
            pos_reg  <= '0;
        end
        else if (cmd.prep)
        begin
            fmt_reg  <= fmt_next;
            step_reg <= '0;
            pos_reg  <= '0;
        end
        else if (cmd.emit)
        begin
            if (name_empty)
            begin
                step_reg <= step_reg + 3'd1;
                pos_reg  <= '0;
            end
            else if (out_fire && seg.kind == SEG_NAME)
            begin
                if (pos_reg + LW'(1) == sel_len)
                begin
                    step_reg <= step_reg + 3'd1;
                    pos_reg  <= '0;
                end
                else
                    pos_reg <= pos_reg + LW'(1);
            end
            else if (out_fire && seg.kind == SEG_CHAR)
                step_reg <= step_reg + 3'd1;
        end
    end

    assign st.line_start = accept && finish && !is_kw;
    assign st.line_done  = out_fire && out_end;

endmodule

@@ verif/c_declaration_symbol_scanner_unit_tb.sv @@
// Self-checking testbench for the declaration symbol scanner top level.
// Depends on cdss_pkg and c_declaration_symbol_scanner_unit; it drives source bytes and
// checks every emitted line character against an in-bench scanner prediction.
`timescale 1ns / 100ps

module c_declaration_symbol_scanner_unit_tb;
    import cdss_pkg::*;

    localparam int NAME_MAX = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } line_item_t;

    logic       clk;
    logic       rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    c_declaration_symbol_scanner_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Source bytes waiting to be offered, and the line characters still owed by the block.
    logic [7:0] source_queue[$];
    line_item_t line_chars_due[$];

    int  error_count = 0;
    int  cycle_count = 0;
    bit  sender_paused;
    bit  calm_stretch;
    bit  hold_request;
    bit  hold_taken;
    int  receiver_hold;

    // Scanner state kept by the predictor.
    int         brace_level;
    int         comment_level;
    bit         quoting;
    logic [7:0] quote_char;
    logic [7:0] last_quoted;
    logic [1:0] pending_mark;
    int         word_len;
    bit         word_overflow;
    logic [7:0] word_buf[NAME_MAX];
    logic [7:0] recent_names[3][NAME_MAX];
    int         recent_lens[3];
    logic [7:0] line_buf[$];

    initial clk = 1'b0;
    always #10 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        error_count++;
    endtask

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    // Case-blind comparison of a stored name slice against a keyword.
    function automatic bit name_equals(input logic [7:0] s[NAME_MAX], input int start,
                                       input int n, input string kw);
        if (n != kw.len()) return 0;
        for (int i = 0; i < n; i++)
            if (to_upper(s[start + i]) != to_upper(kw[i])) return 0;
        return 1;
    endfunction

    function automatic bit recent_is(input int k, input string kw);
        return name_equals(recent_names[k], 0, recent_lens[k], kw);
    endfunction

    task automatic append_name(input int k);
        for (int i = 0; i < recent_lens[k]; i++) line_buf.push_back(recent_names[k][i]);
    endtask

    task automatic compose_declaration_line();
        line_buf.delete();
        if (recent_is(1, "define")) begin
            line_buf.push_back("#"); append_name(1); line_buf.push_back(" "); append_name(2);
        end else if (recent_is(0, "include") && recent_is(2, "h")) begin
            line_buf.push_back("#"); append_name(0); line_buf.push_back(" "); append_name(1);
            line_buf.push_back("."); append_name(2);
        end else if (recent_lens[1] >= 2 &&
                     name_equals(recent_names[1], 2, recent_lens[1] - 2, "def")) begin
            line_buf.push_back("#"); append_name(1); line_buf.push_back(" "); append_name(2);
        end else if (recent_is(1, "char") || recent_is(1, "int") ||
                     recent_is(1, "unsigned") || recent_is(1, "long")) begin
            if (recent_is(0, "extern") || recent_is(0, "static")) begin
                append_name(0); line_buf.push_back(" ");
            end
            append_name(1); line_buf.push_back(" "); append_name(2);
        end else if (recent_is(1, "struct")) begin
            append_name(1); line_buf.push_back(" "); append_name(2);
        end else begin
            append_name(2);
        end
        line_buf.push_back(CH_NL);
    endtask

    function automatic bit word_is_keyword(input int n);
        string kws[11] = '{"int", "struct", "long", "char", "unsigned", "static",
                           "extern", "include", "define", "ifdef", "endif"};
        foreach (kws[i])
            if (name_equals(word_buf, 0, n, kws[i])) return 1;
        return 0;
    endfunction

    // The finished identifier shifts into the history; non-keywords produce a line.
    task automatic close_word();
        int n;
        n = word_overflow ? 0 : word_len;
        recent_names[0] = recent_names[1];
        recent_names[1] = recent_names[2];
        for (int i = 0; i < n; i++) recent_names[2][i] = word_buf[i];
        recent_lens[0] = recent_lens[1];
        recent_lens[1] = recent_lens[2];
        recent_lens[2] = n;
        if (!word_is_keyword(n)) compose_declaration_line();
        word_len = 0;
        word_overflow = 0;
    endtask

    function automatic bit is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    task automatic reset_predictor();
        brace_level   = 0;
        comment_level = 0;
        quoting       = 0;
        quote_char    = 8'h00;
        last_quoted   = 8'h00;
        pending_mark  = LA_NONE;
        word_len      = 0;
        word_overflow = 0;
        foreach (recent_lens[k]) recent_lens[k] = 0;
        foreach (recent_names[k, i]) recent_names[k][i] = 8'h00;
        foreach (word_buf[i]) word_buf[i] = 8'h00;
    endtask

    task automatic scan_plain_byte(input logic [7:0] c_in);
        logic [7:0] c;
        c = c_in;
        if (c == CH_SLASH) begin
            word_len = 0; word_overflow = 0;
            pending_mark = LA_SLASH;
            return;
        end
        if (comment_level != 0) begin
            if (c == CH_STAR) pending_mark = LA_STAR;
            else begin word_len = 0; word_overflow = 0; end
            return;
        end
        if (quoting) begin
            if (c == CH_BSLASH && last_quoted == CH_BSLASH) c = 8'h00;
            if (c == quote_char && last_quoted != CH_BSLASH) quoting = 0;
            last_quoted = c;
            return;
        end
        if (c == CH_SQUOTE || c == CH_DQUOTE) begin
            quoting = 1; last_quoted = 8'h00; quote_char = c;
            return;
        end
        if (c == CH_LBRACE) begin
            if (brace_level < 127) brace_level++;
            return;
        end
        if (c == CH_RBRACE) begin
            word_len = 0; word_overflow = 0;
            if (brace_level > -128) brace_level--;
            return;
        end
        if (brace_level != 0) return;
        if (word_len == 0) begin
            if (is_alpha(c) || c == CH_USCORE) begin
                word_buf[0] = c; word_len = 1; word_overflow = 0;
            end
            return;
        end
        if (is_alpha(c) || (c >= "0" && c <= "9") || c == CH_USCORE || c == CH_DOLLAR) begin
            if (word_len < NAME_MAX) begin
                word_buf[word_len] = c; word_len++;
            end else word_overflow = 1;
            return;
        end
        close_word();
    endtask

    // Predicts the line characters caused by one accepted source byte.
    task automatic predict_scan(input logic [7:0] c);
        logic [1:0] held;
        held = pending_mark;
        line_buf.delete();
        pending_mark = LA_NONE;
        if (held == LA_SLASH && c == CH_STAR) begin
            if (comment_level < 255) comment_level++;
        end else if (held == LA_STAR && c == CH_SLASH) begin
            if (comment_level > 0) comment_level--;
        end else begin
            scan_plain_byte(c);
        end
        foreach (line_buf[i]) begin
            line_item_t it;
            it.ch = line_buf[i];
            it.last = (i == line_buf.size() - 1);
            line_chars_due.push_back(it);
        end
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++) source_queue.push_back(s[i]);
    endtask

    // Random C-like text: mostly well-formed declarations with random names.
    function automatic string random_name();
        string kw[12] = '{"int", "STRUCT", "long", "Char", "unsigned", "static", "extern",
                          "include", "define", "ifdef", "endif", "h"};
        string s;
        int n;
        if ($urandom_range(0, 2) == 0) return kw[$urandom_range(0, 11)];
        s = "";
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            int r;
            byte ch;
            r = $urandom_range(0, 9);
            if (i == 0 || r < 6) ch = 8'($urandom_range("a", "z"));
            else if (r < 8) ch = 8'($urandom_range("0", "9"));
            else ch = (r == 8) ? CH_USCORE : CH_DOLLAR;
            s = {s, " "};
            s.putc(i, ch);
        end
        return s;
    endfunction

    task automatic queue_random_chunk();
        int kind;
        int noise_len;
        kind = $urandom_range(0, 19);
        if (kind < 11) begin
            queue_text({random_name(), " ", random_name(), " ", random_name(), ";"});
        end else if (kind < 13) begin
            queue_text({"int x{", random_name(), "} "});
        end else if (kind < 14) begin
            queue_text({"/* ", random_name(), " /*n*/ */ "});
        end else if (kind < 15) begin
            queue_text({"\"", random_name(), "\\\"x\\\\\" "});
        end else if (kind < 16) begin
            queue_text({"#define ", random_name(), "_def ", random_name(), "\n"});
        end else begin
            // Noise: arbitrary bytes, including the high half and stray delimiters.
            noise_len = $urandom_range(1, 4);
            for (int i = 0; i < noise_len; i++)
                source_queue.push_back(8'($urandom_range(0, 255)));
            queue_text(" ");
        end
    endtask

    // Sender: offers queued bytes; valid holds while a byte waits unaccepted, and may drop at random between items.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            reset_predictor();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_scan(s_axis_tdata);
                void'(source_queue.pop_front());
            end
            if ((!s_axis_tvalid || s_axis_tready || !s_axis_tvalid) &&
                !(s_axis_tvalid && !s_axis_tready)) begin
                if (source_queue.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0) &&
                    !sender_paused && (calm_stretch || $urandom_range(0, 99) >= 21)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= source_queue[0];
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off counted here.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            receiver_hold <= 0;
            hold_taken    <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (line_chars_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected char %02h", m_axis_tdata));
                end else begin
                    line_item_t want;
                    want = line_chars_due.pop_front();
                    if (m_axis_tdata !== want.ch)
                        report_mismatch($sformatf("line_char %02h, want %02h",
                                                  m_axis_tdata, want.ch));
                    if (m_axis_tlast !== want.last)
                        report_mismatch($sformatf("line_end %0b, want %0b",
                                                  m_axis_tlast, want.last));
                end
            end
            if (hold_request && !hold_taken) begin
                hold_taken    <= 1'b1;
                receiver_hold <= HOLD_CYCLES;
                m_axis_tready <= 1'b0;
            end else if (receiver_hold > 0) begin
                receiver_hold <= receiver_hold - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm_stretch || ($urandom_range(0, 99) >= 21);
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("c_declaration_symbol_scanner_unit verification failed");
            $finish;
        end
    end

    initial begin
        sender_paused = 0;
        calm_stretch  = 0;
        hold_request  = 0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: each line format, keywords in mixed case, an over-long name,
        // slash dropping a name, nested comments and a comment opener inside a literal,
        // escaped quotes, braces, and bytes from the high half.
        queue_text("extern INT cnt; struct nd n; #include <a.h> ");
        queue_text("#define MX 9 xydef q abcdefghijklmnopq ");
        queue_text("ab/cd /*a/*b*/c*/ \"s/*x*/\" w{q}z ");
        queue_text("'\\'' \"\\\\\" e1$ ");
        source_queue.push_back(8'hFF);
        source_queue.push_back(8'h80);
        queue_text("t ");
        source_queue.push_back(8'h00);
        queue_text("u ");
        wait (source_queue.size() == 0);

        // Sender pause until every expected character has drained.
        sender_paused = 1;
        wait (line_chars_due.size() == 0);
        repeat (4) @(posedge clk);
        sender_paused = 0;

        // Long receiver hold-off while the sender keeps offering.
        hold_request = 1;
        queue_text("alpha beta; ");
        wait (source_queue.size() == 0);

        // A stretch with no idling on either side.
        calm_stretch = 1;
        queue_random_chunk();
        wait (source_queue.size() == 0);
        wait (line_chars_due.size() == 0);
        calm_stretch = 0;

        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("c_declaration_symbol_scanner_unit verification clean");
        else
            $display("c_declaration_symbol_scanner_unit verification failed");
        $finish;
    end

endmodule
